FILE: hdl/unsigned_to_decimal_ascii_macros.svh
// Assertion macros for the decimal ASCII converter.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef UNSIGNED_TO_DECIMAL_ASCII_MACROS_SVH
`define UNSIGNED_TO_DECIMAL_ASCII_MACROS_SVH

// Check that a condition implies a property in the same cycle.
`define U2DA_ASSERT_NOW(lbl, cond, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error("u2da assertion failed");

// Check that a condition implies a property in the following cycle.
`define U2DA_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error("u2da assertion failed");

`endif

FILE: hdl/u2da_pkg.sv
// Shared constants, state type and command/status structs of the converter.
// No dependencies; used by the controller, the datapath and the top level.
package u2da_pkg;

  localparam int DataBits     = 32;  // width of the input value field
  localparam int ValueBitsDef = 32;  // default converted width
  localparam int MaxDigits    = 10;  // digits of the largest 32-bit value
  localparam int DigitBits    = 4;
  localparam int CountBits    = 4;
  localparam int CharBits     = 6;
  localparam int OutDataBits  = 16;  // 10 payload bits padded to two bytes

  localparam logic [CharBits-1:0] AsciiZero = 6'd48;
  localparam logic [DigitBits-1:0] DigitBase = 4'd10;

  // floor(v / 10) == (v * Recip10) >> Recip10Shift for every 32-bit v
  localparam logic [31:0] Recip10      = 32'hCCCC_CCCD;
  localparam int          Recip10Shift = 35;

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StEmit
  } state_e;

  typedef struct packed {
    logic load;      // take a new value, clear the digit count
    logic step;      // peel one digit off the value
    logic out_load;  // move the next digit into the output register
  } cmd_t;

  typedef struct packed {
    logic conv_done;   // the digit produced this step is the last one
    logic last_digit;  // the digit about to be loaded is the least significant
    logic out_valid;   // the output register holds an untaken beat
  } sts_t;

endpackage

FILE: hdl/unsigned_to_decimal_ascii.sv
// Top level of the unsigned binary to decimal ASCII converter.
// Depends on u2da_pkg, u2da_ctrl and u2da_dpath.

// Takes one unsigned value per input beat and returns its decimal digits as
// ASCII characters, most significant first, one output beat per digit, with
// no leading zeros; zero gives the single digit '0'. Every beat carries the
// total digit count, and tlast marks the least significant digit. Only the
// low VALUE_BITS bits of the input (at most 32) are converted. A value
// occupies the block while it is accepted, while the shared divide-by-ten
// unit peels one digit a cycle, and while its digits move through the
// single output register. The next value is accepted while the last digit
// still waits in that register. There is no configuration and no stored
// state between values.
module unsigned_to_decimal_ascii #(
  parameter int VALUE_BITS = u2da_pkg::ValueBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input beat
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [u2da_pkg::DataBits-1:0]      s_axis_tdata,   // [31:0] value
  // result beat
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [u2da_pkg::OutDataBits-1:0]   m_axis_tdata,   // [5:0] digit_char,
                                                             // [9:6] digit_count,
                                                             // [15:10] zero
  output logic                               m_axis_tlast    // is_last
);
  import u2da_pkg::*;

  cmd_t                 cmd;
  sts_t                 sts;
  logic [CharBits-1:0]  out_char;
  logic [CountBits-1:0] out_count;

  // sequence accept, conversion and emission
  u2da_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // hold the value, divide by ten, buffer digits, drive the result beat
  u2da_dpath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_value_i  (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_char_o  (out_char),
    .out_count_o (out_count),
    .out_last_o  (m_axis_tlast)
  );

  // pack the result fields from the lowest bit up, pad to two bytes
  assign m_axis_tdata = {(OutDataBits - CharBits - CountBits)'(0), out_count, out_char};

endmodule

FILE: hdl/u2da_ctrl.sv
// Sequencer of the converter: accept, convert one digit a cycle, emit.
// Depends on u2da_pkg for the state type and the command/status structs.
module u2da_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            out_ready_i,
  input  u2da_pkg::sts_t  sts_i,
  output u2da_pkg::cmd_t  cmd_o
);
  import u2da_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StConv;
        end
      end
      StConv: begin
        cmd_o.step = 1'b1;
        if (sts_i.conv_done) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        // advance only when the output register is free or being emptied
        if (!sts_i.out_valid || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          if (sts_i.last_digit) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

FILE: hdl/u2da_dpath.sv
// Datapath of the converter: value register, divide-by-ten unit, digit
// buffer and output register. Depends on u2da_pkg and the macros header.
`include "unsigned_to_decimal_ascii_macros.svh"

module u2da_dpath #(
  parameter int VALUE_BITS = u2da_pkg::ValueBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [u2da_pkg::DataBits-1:0]       in_value_i,
  input  logic                                out_ready_i,
  input  u2da_pkg::cmd_t                      cmd_i,
  output u2da_pkg::sts_t                      sts_o,
  output logic                                out_valid_o,
  output logic [u2da_pkg::CharBits-1:0]       out_char_o,
  output logic [u2da_pkg::CountBits-1:0]      out_count_o,
  output logic                                out_last_o
);
  import u2da_pkg::*;

  // bits above the 32-bit field never reach the converter
  localparam int EffBits = (VALUE_BITS < DataBits) ? VALUE_BITS : DataBits;

  logic [EffBits-1:0]   val_q;
  logic [CountBits-1:0] cnt_q;
  logic [CountBits-1:0] rd_idx_q;
  logic [DigitBits-1:0] digits_q [MaxDigits];
  logic                 out_valid_q;
  logic [CharBits-1:0]  out_char_q;
  logic [CountBits-1:0] out_count_q;
  logic                 out_last_q;

  logic [DataBits-1:0]   val_ext;
  logic [2*DataBits-1:0] prod;
  logic [DataBits-1:0]   quot;
  logic [DataBits-1:0]   rem_full;
  logic [DigitBits-1:0]  rem;

  // divide by ten through the reciprocal, remainder by shift and subtract
  assign val_ext  = DataBits'(val_q);
  assign prod     = (2*DataBits)'(val_ext) * (2*DataBits)'(Recip10);
  assign quot     = DataBits'(prod[2*DataBits-1:Recip10Shift]);
  assign rem_full = val_ext - (quot << 3) - (quot << 1);
  assign rem      = rem_full[DigitBits-1:0];

  assign sts_o.conv_done  = (quot == '0) || (cnt_q == CountBits'(MaxDigits - 1));
  assign sts_o.last_digit = (rd_idx_q == '0);
  assign sts_o.out_valid  = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        cnt_q <= '0;
      end else if (cmd_i.step) begin
        cnt_q    <= cnt_q + 1'b1;
        rd_idx_q <= cnt_q;  // ends up pointing at the most significant digit
      end else if (cmd_i.out_load) begin
        rd_idx_q <= rd_idx_q - 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q <= in_value_i[EffBits-1:0];
    end else if (cmd_i.step) begin
      val_q           <= quot[EffBits-1:0];
      digits_q[cnt_q] <= rem;
    end
    if (cmd_i.out_load) begin
      out_char_q  <= AsciiZero + CharBits'(digits_q[rd_idx_q]);
      out_count_q <= cnt_q;
      out_last_q  <= (rd_idx_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_count_o = out_count_q;
  assign out_last_o  = out_last_q;

  `U2DA_ASSERT_NOW(a_rem_is_digit, cmd_i.step, rem_full < DataBits'(DigitBase))
  `U2DA_ASSERT_NOW(a_step_in_range, cmd_i.step, cnt_q < CountBits'(MaxDigits))
  `U2DA_ASSERT_NEXT(a_count_matches, cmd_i.out_load, (out_count_q != '0) && (out_count_q > $past(rd_idx_q)))

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the unsigned binary to decimal ASCII converter.
// Depends on u2da_pkg and the unsigned_to_decimal_ascii top level; drives values
// over the input stream and checks every digit beat against its own predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import u2da_pkg::*;

  localparam int ValueBits   = ValueBitsDef;
  localparam int DrainCycles = 4 * MaxDigits;  // idle time before the final verdict
  localparam int RandomItems = 65;             // per idling phase, three phases

  // One expected result beat: the two tdata fields, lowest first, and tlast.
  typedef struct packed {
    logic [CharBits-1:0]  digit_char;
    logic [CountBits-1:0] digit_count;
    logic                 is_last;
  } digit_beat_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [DataBits-1:0]    s_axis_tdata;   // [31:0] value
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OutDataBits-1:0] m_axis_tdata;   // [5:0] digit_char, [9:6] digit_count,
                                          // [15:10] zero
  logic                   m_axis_tlast;   // is_last

  digit_beat_t expected_digits[$];
  digit_beat_t wanted_digit;
  int          fail_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_off_request;
  int          hold_off_left;

  unsigned_to_decimal_ascii #(
    .VALUE_BITS(ValueBits)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Work out the digit beats of one accepted value and queue them, most
  // significant digit first. Bits above the converted width are masked off.
  function automatic void predict_digits(input logic [DataBits-1:0] value);
    logic [63:0] remain;
    logic [63:0] mask;
    logic [3:0]  digits [MaxDigits];
    int          n;
    int          k;
    digit_beat_t beat;
    mask   = (ValueBits >= 64) ? '1 : ((64'd1 << ValueBits) - 64'd1);
    remain = {32'd0, value} & mask & 64'hFFFF_FFFF;
    n      = 0;
    do begin
      digits[n] = 4'(remain % 64'd10);
      remain    = remain / 64'd10;
      n++;
    end while (remain != 64'd0 && n < MaxDigits);
    for (k = 0; k < n; k++) begin
      beat.digit_char  = AsciiZero + CharBits'(digits[n - 1 - k]);
      beat.digit_count = CountBits'(n);
      beat.is_last     = (k == n - 1);
      expected_digits.push_back(beat);
    end
  endfunction

  // Offer one value and hold it until the block takes it. Entered just after
  // a rising edge; leaves tvalid high so back-to-back beats need no toggle.
  task automatic send_value(input logic [DataBits-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_digits(value);
  endtask

  // Drop tvalid and wait until every queued digit has come out.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_digits.size() != 0) @(posedge clk_i);
  endtask

  // Spread the digit count evenly: pick a random width, then a value in it,
  // with a share of single digits and the upper boundary thrown in.
  function automatic logic [DataBits-1:0] random_value();
    int                  width;
    logic [DataBits-1:0] value;
    width = $urandom_range(DataBits, 1);
    value = $urandom;
    if (width < DataBits) value = value & ((32'd1 << width) - 32'd1);
    case ($urandom_range(9))
      0: value = $urandom_range(9);
      1: value = 32'hFFFF_FFFF - $urandom_range(3);
      default: ;
    endcase
    return value;
  endfunction

  // Result side: check each taken beat against the oldest expectation, then
  // pick the next tready. A requested hold-off is counted down here.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_digits.size() == 0) begin
          $display("%0t: unexpected beat tdata %h tlast %b", $time, m_axis_tdata,
                   m_axis_tlast);
          fail_count++;
        end else begin
          wanted_digit = expected_digits.pop_front();
          if (m_axis_tdata[CharBits-1:0] !== wanted_digit.digit_char) begin
            $display("%0t: digit_char expected %0d got %0d", $time,
                     wanted_digit.digit_char, m_axis_tdata[CharBits-1:0]);
            fail_count++;
          end
          if (m_axis_tdata[CharBits +: CountBits] !== wanted_digit.digit_count) begin
            $display("%0t: digit_count expected %0d got %0d", $time,
                     wanted_digit.digit_count, m_axis_tdata[CharBits +: CountBits]);
            fail_count++;
          end
          if (m_axis_tlast !== wanted_digit.is_last) begin
            $display("%0t: is_last expected %b got %b", $time, wanted_digit.is_last,
                     m_axis_tlast);
            fail_count++;
          end
          if (m_axis_tdata[OutDataBits-1:CharBits+CountBits] !== '0) begin
            $display("%0t: tdata padding expected 0 got %h", $time,
                     m_axis_tdata[OutDataBits-1:CharBits+CountBits]);
            fail_count++;
          end
        end
      end
      if (hold_off_request > 0) begin
        hold_off_left    = hold_off_request;
        hold_off_request = 0;
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Boundaries of every digit count, zero, the all-ones value and
  // alternating bit patterns so that each input bit is seen at 0 and 1.
  task automatic test_directed();
    logic [DataBits-1:0] edges [$];
    logic [DataBits-1:0] power;
    power = 32'd1;
    edges = {32'd0, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000};
    repeat (MaxDigits) begin
      edges.push_back(power);
      edges.push_back(power - 32'd1);
      if (power <= 32'd429_496_729) power = power * 32'd10;
    end
    foreach (edges[i]) send_value(edges[i]);
    drain_results();
  endtask

  // Random values under the current idling setting.
  task automatic test_random(input int items);
    repeat (items) send_value(random_value());
  endtask

  // Hold the result side off for a long stretch while values keep coming,
  // so the output register fills and the input stalls; then wait it out.
  task automatic test_backpressure();
    hold_off_request = 300;
    repeat (30) send_value(random_value());
    drain_results();
  endtask

  initial begin
    fail_count       = 0;
    hold_off_request = 0;
    hold_off_left    = 0;
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 17;
    recv_idle_pct = 65;
    test_directed();
    test_random(RandomItems);
    test_backpressure();

    send_idle_pct = 65;
    recv_idle_pct = 17;
    test_random(RandomItems);
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(RandomItems);
    drain_results();

    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // Stop a hung run.
  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
